/* rtl/dsb_pkg.sv */
// Shared types and constants of the delay-and-sum beamformer.
// No dependencies; every other file of the block refers to it by scoped names.
package dsb_pkg;

  // Datapath shape
  localparam int MICS        = 4;
  localparam int MIC_W       = 2;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 10;
  localparam int DELAY_W     = 16;
  localparam int WHOLE_W     = DELAY_W - FRAC_BITS;
  localparam int COUNT_W     = 3;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_BITS;
  localparam int BLEND_W     = SAMPLE_W + FRAC_BITS + 1;
  localparam int SUM_W       = BLEND_W + MIC_W;
  localparam int QUOT_W      = SUM_W - FRAC_BITS - 1;

  // floor(u / 3) == (u * RECIP3) >> RECIP_SHIFT for every u below 2^19
  localparam logic [QUOT_W-1:0] RECIP3      = QUOT_W'(174763);
  localparam int                RECIP_SHIFT = 19;

  localparam logic [QUOT_W-1:0] SAT_POS = QUOT_W'(32767);
  localparam logic [QUOT_W-1:0] SAT_NEG = QUOT_W'(32768);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIC_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PASSTHROUGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY0      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY1      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY2      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY3      = 3'd5;

  // Per-microphone tap control, travels alongside the memory read
  typedef struct packed {
    logic                       active;   // microphone takes part in the sum
    logic                       last;     // final microphone of the sweep
    logic                       use_cur;  // near tap is the current input
    logic                       a_ok;     // near tap was written since reset
    logic                       b_ok;     // far tap was written since reset
    logic [FRAC_BITS-1:0]       frac;
    logic [SAMPLE_W-1:0]        cur;
  } tap_ctl_t;

endpackage

/* rtl/dsb_mem.sv */
// Delay-line sample memory: one write port, two registered read ports.
// Uses dsb_pkg for the sample width.
module dsb_mem #(
  parameter int AW = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [dsb_pkg::SAMPLE_W-1:0]  wdata,
  input  logic [AW-1:0]                 raddr_a,
  input  logic [AW-1:0]                 raddr_b,
  output logic [dsb_pkg::SAMPLE_W-1:0]  rdata_a,
  output logic [dsb_pkg::SAMPLE_W-1:0]  rdata_b
);

  logic [dsb_pkg::SAMPLE_W-1:0] mem [2**AW];

  // Reads return the old contents when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* rtl/dsb_blend.sv */
// Fractional-delay blend and accumulation over the microphones of one item.
// Uses dsb_pkg (tap_ctl_t and widths); fed by dsb_mem read data.
module dsb_blend (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  dsb_pkg::tap_ctl_t                    ctl,
  input  logic [dsb_pkg::SAMPLE_W-1:0]         rd_a,
  input  logic [dsb_pkg::SAMPLE_W-1:0]         rd_b,
  output logic signed [dsb_pkg::SUM_W-1:0]     sum,
  output logic                                 done
);

  logic signed [dsb_pkg::SAMPLE_W-1:0]        a_sel;
  logic signed [dsb_pkg::SAMPLE_W-1:0]        b_sel;
  logic signed [dsb_pkg::DIFF_W-1:0]          diff;
  logic signed [dsb_pkg::DIFF_W+dsb_pkg::FRAC_BITS:0] prod_full;
  logic signed [dsb_pkg::PROD_W-1:0]          prod;
  logic signed [dsb_pkg::SAMPLE_W-1:0]        a_r;
  logic                                       p_active;
  logic                                       p_last;
  logic signed [dsb_pkg::BLEND_W-1:0]         blend;

  // a*(1 - f) + b*f rewritten as a + (b - a)*f to need one multiplier
  always_comb begin
    a_sel = ctl.use_cur ? $signed(ctl.cur) : (ctl.a_ok ? $signed(rd_a) : '0);
    b_sel = ctl.b_ok ? $signed(rd_b) : '0;
    diff  = $signed({b_sel[dsb_pkg::SAMPLE_W-1], b_sel})
          - $signed({a_sel[dsb_pkg::SAMPLE_W-1], a_sel});
    prod_full = diff * $signed({1'b0, ctl.frac});
  end

  always_ff @(posedge clk) begin
    prod <= prod_full[dsb_pkg::PROD_W-1:0];
    a_r  <= a_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_active <= 1'b0;
      p_last   <= 1'b0;
    end else begin
      p_active <= ctl.active;
      p_last   <= ctl.last;
    end
  end

  assign blend = $signed({a_r[dsb_pkg::SAMPLE_W-1], a_r, {dsb_pkg::FRAC_BITS{1'b0}}}) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      done <= 1'b0;
    end else begin
      done <= p_last;
      if (clear) begin
        sum <= '0;
      end else if (p_active) begin
        sum <= sum + {{dsb_pkg::MIC_W{blend[dsb_pkg::BLEND_W-1]}}, blend};
      end
    end
  end

endmodule

/* rtl/dsb_scale.sv */
// Divide the blended sum by (count << FRAC_BITS), truncating toward zero,
// and saturate to 16 bits. Three pipeline stages. Uses dsb_pkg.
module dsb_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [dsb_pkg::SUM_W-1:0]     sum,
  input  logic [dsb_pkg::COUNT_W-1:0]          count,
  output logic                                 done,
  output logic [dsb_pkg::SAMPLE_W-1:0]         q
);

  logic [dsb_pkg::SUM_W-1:0]      mag;
  logic [dsb_pkg::QUOT_W-1:0]     u1;
  logic                           neg1;
  logic [dsb_pkg::COUNT_W-1:0]    count1;
  logic                           v1;
  logic [2*dsb_pkg::QUOT_W-1:0]   prod3;
  logic [dsb_pkg::QUOT_W-1:0]     quot_next;
  logic [dsb_pkg::QUOT_W-1:0]     quot2;
  logic                           neg2;
  logic                           v2;
  logic [dsb_pkg::SAMPLE_W-1:0]   q_next;

  // Truncating the magnitude twice equals one truncation of the full quotient
  assign mag = sum[dsb_pkg::SUM_W-1] ? dsb_pkg::SUM_W'(-sum) : dsb_pkg::SUM_W'(sum);

  always_ff @(posedge clk) begin
    u1     <= mag[dsb_pkg::FRAC_BITS +: dsb_pkg::QUOT_W];
    neg1   <= sum[dsb_pkg::SUM_W-1];
    count1 <= count;
  end

  always_comb begin
    prod3 = u1 * dsb_pkg::RECIP3;
    case (count1)
      3'd2:    quot_next = u1 >> 1;
      3'd3:    quot_next = dsb_pkg::QUOT_W'(prod3 >> dsb_pkg::RECIP_SHIFT);
      3'd4:    quot_next = u1 >> 2;
      default: quot_next = u1;
    endcase
  end

  always_ff @(posedge clk) begin
    quot2 <= quot_next;
    neg2  <= neg1;
  end

  always_comb begin
    if (neg2) begin
      q_next = (quot2 > dsb_pkg::SAT_NEG) ? dsb_pkg::SAMPLE_W'(dsb_pkg::SAT_NEG)
                                          : dsb_pkg::SAMPLE_W'(~quot2 + 1'b1);
    end else begin
      q_next = (quot2 > dsb_pkg::SAT_POS) ? dsb_pkg::SAMPLE_W'(dsb_pkg::SAT_POS)
                                          : dsb_pkg::SAMPLE_W'(quot2);
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

endmodule

/* rtl/delay_and_sum_beamformer.sv */
// Delay-and-sum beamformer with fractional per-microphone delays (top level).
// Uses dsb_pkg; instantiates dsb_mem, dsb_blend and dsb_scale.
//
// Each item is one sample instant carrying one signed 16-bit sample from each
// of four microphones; each item yields exactly one mono_sample. Outside
// passthrough, every microphone keeps a delay line of its DELAY_DEPTH most
// recent samples in a single synchronous memory (one row per microphone).
// For each active microphone the block reads the sample at the whole part of
// its delay register and the sample one instant older, blends them linearly
// by the 10-bit fraction, sums the blends, divides by the microphone count
// (truncating toward zero) and saturates to 16 bits. A mic_count of zero acts
// as one, anything above four as four. A whole delay of DELAY_DEPTH or more is
// clamped to DELAY_DEPTH-1 with a zero fraction. The delay lines read as zero
// until written after reset; a fill counter tracks that, so reset needs no
// clearing pass and the block takes an item in the first cycle after reset.
// Sequence: an averaged item sweeps the memory one microphone per cycle, where
// each cycle reads both taps and writes the new sample of that microphone,
// then passes the two-stage blend multiply and accumulate pipeline, the
// three-stage divider, the result capture and the output load. A passthrough
// item goes straight to the output load, and it leaves the delay lines and
// write pointer untouched.
// sample_stall is high while an item is in flight; a finished result waits in
// the output register, so the next item is accepted while mono_stall holds
// the previous one. Configuration writes are always accepted (cfg_ready is
// tied high) and must only be issued while the block is idle; indexes beyond
// the register list are dropped.
module delay_and_sum_beamformer #(
  parameter int DELAY_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [dsb_pkg::SAMPLE_W-1:0]   mic0_sample,
  input  logic signed [dsb_pkg::SAMPLE_W-1:0]   mic1_sample,
  input  logic signed [dsb_pkg::SAMPLE_W-1:0]   mic2_sample,
  input  logic signed [dsb_pkg::SAMPLE_W-1:0]   mic3_sample,
  // result channel
  output logic                                  mono_valid,
  input  logic                                  mono_stall,
  output logic signed [dsb_pkg::SAMPLE_W-1:0]   mono_sample,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dsb_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dsb_pkg::DELAY_W-1:0]           cfg_data
);

  localparam int IDX_W  = $clog2(DELAY_DEPTH);
  localparam int KW     = $clog2(DELAY_DEPTH + 1);
  localparam int DW     = KW + 1;
  localparam int ADDR_W = dsb_pkg::MIC_W + IDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  // Index of the entry k instants back from base, wrapping around the line
  function automatic logic [IDX_W-1:0] back_index(input logic [IDX_W-1:0] base,
                                                  input logic [KW-1:0]    k);
    logic [DW-1:0] t;
    t = DW'(base) - DW'(k);
    if (t[DW-1]) begin
      t = t + DW'(DELAY_DEPTH);
    end
    return t[IDX_W-1:0];
  endfunction

  // Configuration registers
  logic [dsb_pkg::COUNT_W-1:0]  mic_count;
  logic                         passthrough_mode;
  logic [dsb_pkg::DELAY_W-1:0]  delay_reg [dsb_pkg::MICS];

  // Sequencer and item state
  logic [1:0]                   state;
  logic [dsb_pkg::MIC_W-1:0]    mic;
  logic [dsb_pkg::COUNT_W-1:0]  count_eff;
  logic [dsb_pkg::COUNT_W-1:0]  count_r;
  logic [dsb_pkg::SAMPLE_W-1:0] cur [dsb_pkg::MICS];
  logic [dsb_pkg::SAMPLE_W-1:0] result;
  logic [IDX_W-1:0]             wp;
  logic [KW-1:0]                fill;
  logic                         accept;
  logic                         out_load;

  // Tap computation for the microphone being swept
  logic [dsb_pkg::DELAY_W-1:0]  dreg;
  logic [dsb_pkg::WHOLE_W-1:0]  whole_raw;
  logic [KW-1:0]                whole;
  logic [KW-1:0]                k_b;
  logic [dsb_pkg::FRAC_BITS-1:0] frac;
  logic [IDX_W-1:0]             idx_a;
  logic [IDX_W-1:0]             idx_b;
  dsb_pkg::tap_ctl_t            ctl_next;
  dsb_pkg::tap_ctl_t            ctl;

  // Memory and datapath links
  logic                         mem_we;
  logic [dsb_pkg::SAMPLE_W-1:0] rd_a;
  logic [dsb_pkg::SAMPLE_W-1:0] rd_b;
  logic signed [dsb_pkg::SUM_W-1:0] sum;
  logic                         blend_done;
  logic                         scale_done;
  logic [dsb_pkg::SAMPLE_W-1:0] scale_q;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_load     = (state == S_OUT) && (!mono_valid || !mono_stall);
  assign mem_we       = (state == S_SWEEP);

  // Configuration writes; values are masked to the register width
  always_ff @(posedge clk) begin
    if (rst) begin
      mic_count        <= dsb_pkg::COUNT_W'(1);
      passthrough_mode <= 1'b1;
      delay_reg        <= '{default: '0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dsb_pkg::REG_MIC_COUNT:   mic_count        <= cfg_data[dsb_pkg::COUNT_W-1:0];
        dsb_pkg::REG_PASSTHROUGH: passthrough_mode <= cfg_data[0];
        dsb_pkg::REG_DELAY0:      delay_reg[0]     <= cfg_data;
        dsb_pkg::REG_DELAY1:      delay_reg[1]     <= cfg_data;
        dsb_pkg::REG_DELAY2:      delay_reg[2]     <= cfg_data;
        dsb_pkg::REG_DELAY3:      delay_reg[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the microphone count into 1..MICS
  always_comb begin
    if (mic_count == '0) begin
      count_eff = dsb_pkg::COUNT_W'(1);
    end else if (mic_count > dsb_pkg::COUNT_W'(dsb_pkg::MICS)) begin
      count_eff = dsb_pkg::COUNT_W'(dsb_pkg::MICS);
    end else begin
      count_eff = mic_count;
    end
  end

  // Split the delay register, clamp an over-long whole part, find both taps
  always_comb begin
    dreg      = delay_reg[mic];
    whole_raw = dreg[dsb_pkg::DELAY_W-1:dsb_pkg::FRAC_BITS];
    if (32'(whole_raw) >= DELAY_DEPTH) begin
      whole = KW'(DELAY_DEPTH - 1);
      frac  = '0;
    end else begin
      whole = KW'(whole_raw);
      frac  = dreg[dsb_pkg::FRAC_BITS-1:0];
    end
    k_b   = whole + 1'b1;
    idx_a = back_index(wp, whole);
    idx_b = back_index(wp, k_b);

    ctl_next = '0;
    if (state == S_SWEEP) begin
      ctl_next.active  = (dsb_pkg::COUNT_W'(mic) < count_r);
      ctl_next.last    = (mic == dsb_pkg::MIC_W'(dsb_pkg::MICS - 1));
      ctl_next.use_cur = (whole == '0);
      // a tap k back is only valid once k samples have been written
      ctl_next.a_ok    = (whole <= fill);
      ctl_next.b_ok    = (k_b <= fill);
      ctl_next.frac    = frac;
      ctl_next.cur     = cur[mic];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

  // Sequencer: accept, sweep the microphones and wait for the divider (both skipped in passthrough), deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mic   <= '0;
      wp    <= '0;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mic   <= '0;
            state <= passthrough_mode ? S_OUT : S_SWEEP;
          end
        end
        S_SWEEP: begin
          mic <= mic + 1'b1;
          if (mic == dsb_pkg::MIC_W'(dsb_pkg::MICS - 1)) begin
            // advance the write pointer once all rows hold the new samples
            wp    <= (wp == IDX_W'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
            fill  <= (fill == KW'(DELAY_DEPTH)) ? fill : fill + 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (scale_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item payload: hold the samples and the clamped count for the sweep, and the result (mic 0 in passthrough)
  always_ff @(posedge clk) begin
    if (accept) begin
      cur[0]  <= mic0_sample;
      cur[1]  <= mic1_sample;
      cur[2]  <= mic2_sample;
      cur[3]  <= mic3_sample;
      count_r <= count_eff;
      result  <= mic0_sample;
    end else if ((state == S_WAIT) && scale_done) begin
      result  <= scale_q;
    end
  end

  // Output register parts the result side from the sample side
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_valid <= 1'b0;
    end else if (out_load) begin
      mono_valid <= 1'b1;
    end else if (!mono_stall) begin
      mono_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mono_sample <= result;
    end
  end

  dsb_mem #(
    .AW (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   ({mic, wp}),
    .wdata   (cur[mic]),
    .raddr_a ({mic, idx_a}),
    .raddr_b ({mic, idx_b}),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  dsb_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .clear (accept),
    .ctl   (ctl),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .sum   (sum),
    .done  (blend_done)
  );

  dsb_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (blend_done),
    .sum   (sum),
    .count (count_r),
    .done  (scale_done),
    .q     (scale_q)
  );

endmodule

/* rtl/dsb_checker.sv */
// Port-level checks of the beamformer, bound to the top level.
// Depends on dsb_pkg for widths and on delay_and_sum_beamformer for the bind.
module dsb_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 sample_valid,
  input logic                                 sample_stall,
  input logic                                 mono_valid,
  input logic                                 mono_stall,
  input logic [dsb_pkg::SAMPLE_W-1:0]         mono_sample
);

  // A held result keeps its value until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    mono_valid && mono_stall |=> mono_valid && $stable(mono_sample))
    else $error("result changed or dropped while stalled");

  // An accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("block not busy after accepting an item");

  // A new result only appears from an item in flight
  a_source: assert property (@(posedge clk) disable iff (rst)
    $rose(mono_valid) |-> $past(sample_stall))
    else $error("result appeared with no item in flight");

  // Reset empties the output and frees the input
  a_reset: assert property (@(posedge clk)
    rst |=> !mono_valid && !sample_stall)
    else $error("reset did not clear the handshake state");

endmodule

bind delay_and_sum_beamformer dsb_checker u_dsb_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .mono_valid   (mono_valid),
  .mono_stall   (mono_stall),
  .mono_sample  (mono_sample)
);
